>>> hw/rtl/upbf_pkg.sv
// ----------------------------------------------------------------------------
// upbf_pkg
// Shared constants, types and helpers of the URL pattern block filter.
// ----------------------------------------------------------------------------
package upbf_pkg;

    localparam int NumEntries = 32;
    localparam int MaxLen     = 32;
    localparam int CountBits  = 32;
    localparam int IdxW       = $clog2(NumEntries);
    localparam int PosW       = $clog2(MaxLen);
    localparam int LenW       = $clog2(MaxLen + 1);

    localparam logic [1:0] OP_URL    = 2'd0;
    localparam logic [1:0] OP_PBYTE  = 2'd1;
    localparam logic [1:0] OP_HEADER = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic            accept;
        logic            scan_rd;
        logic [IdxW-1:0] scan_addr;
        logic            finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/url_pattern_block_filter.sv
// ----------------------------------------------------------------------------
// url_pattern_block_filter
// Multi-pattern substring filter over a streamed URL with allow/block rules.
// ----------------------------------------------------------------------------
// Operation: a URL byte beat is accepted, every table entry is read and
//   compared, the last compare drains; a last byte then registers the result.
// Throughput: set by the single-read pattern banks, one table entry per cycle;
//   a new URL byte waits for the last scan; table and clear beats need no scan.
// Reset: synchronous on aresetn low; table lengths, allow marks, window fill,
//   flags and counter clear at once, filtering enabled. No clearing pass.
// ----------------------------------------------------------------------------
module url_pattern_block_filter (
    input  logic        aclk,
    input  logic        aresetn,
    // config: filter_enabled
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] entry_index, [9:5] char_pos, [17:10] char_byte,
    // [23:18] entry_length, [24] entry_is_allow, [25] byte_present, rest zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    // url_last
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] decision, [1] matched_allow, [33:2] blocked_total, rest zero
    output logic [39:0] m_axis_tdata
);

    upbf_pkg::ctrl_cmd_t  cmd;
    upbf_pkg::dp_status_t status;
    logic                 dec, matched;
    logic [31:0]          total;

    // Sequencer: accept beats, step through table entries.
    upbf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .op            (s_axis_tuser),
        .byte_present  (s_axis_tdata[25]),
        .url_last      (s_axis_tlast),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Datapath: table storage, window compare, decision and result register.
    upbf_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .op             (s_axis_tuser),
        .entry_index    (s_axis_tdata[4:0]),
        .char_pos       (s_axis_tdata[9:5]),
        .char_byte      (s_axis_tdata[17:10]),
        .entry_length   (s_axis_tdata[23:18]),
        .entry_is_allow (s_axis_tdata[24]),
        .byte_present   (s_axis_tdata[25]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_axis_tready  (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_decision   (dec),
        .out_matched    (matched),
        .out_total      (total)
    );

    assign m_axis_tdata = {6'd0, total, matched, dec};

    // A result is only written into a free or draining output register.
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over pending beat");

    // No beat is taken while the table is being scanned.
    a_scan_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> !s_axis_tready)
        else $error("beat accepted during scan");

    // The output only goes valid after a finish command.
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(cmd.finish))
        else $error("result without finish");

    // Block and allow are never both reported.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(dec && matched))
        else $error("allow and block both set");

endmodule

>>> hw/rtl/upbf_ram.sv
// ----------------------------------------------------------------------------
// upbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module upbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/upbf_ctrl.sv
// ----------------------------------------------------------------------------
// upbf_ctrl
// Sequencer: accepts beats and walks the pattern table one entry per cycle.
// ----------------------------------------------------------------------------
module upbf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [1:0]             op,
    input  logic                   byte_present,
    input  logic                   url_last,
    input  logic                   m_axis_tready,
    input  upbf_pkg::dp_status_t   status,
    output upbf_pkg::ctrl_cmd_t    cmd
);

    upbf_pkg::state_t            state_reg, state_next;
    logic [upbf_pkg::IdxW-1:0]   cnt_reg, cnt_next;
    logic                        last_reg, last_next;
    logic                        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= upbf_pkg::ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        s_axis_tready = 1'b0;
        accept        = 1'b0;
        cmd           = '0;
        cmd.scan_addr = cnt_reg;
        unique case (state_reg)
            upbf_pkg::ST_IDLE: begin
                s_axis_tready = !status.out_full || m_axis_tready;
                accept        = s_axis_tvalid && s_axis_tready;
                cmd.accept    = accept;
                if (accept && op == upbf_pkg::OP_URL) begin
                    if (byte_present) begin
                        state_next = upbf_pkg::ST_SCAN;
                        cnt_next   = '0;
                        last_next  = url_last;
                    end else if (url_last) begin
                        cmd.finish = 1'b1;
                    end
                end
            end
            upbf_pkg::ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == upbf_pkg::IdxW'(upbf_pkg::NumEntries - 1)) begin
                    state_next = upbf_pkg::ST_DRAIN;
                end
            end
            upbf_pkg::ST_DRAIN: begin
                state_next = last_reg ? upbf_pkg::ST_FINISH : upbf_pkg::ST_IDLE;
            end
            upbf_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = upbf_pkg::ST_IDLE;
            end
            default: begin
                state_next = upbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/upbf_dp.sv
// ----------------------------------------------------------------------------
// upbf_dp
// Datapath: pattern table, URL window, entry compare, counter, result register.
// ----------------------------------------------------------------------------
module upbf_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  upbf_pkg::ctrl_cmd_t         cmd,
    output upbf_pkg::dp_status_t        status,
    input  logic [1:0]                  op,
    input  logic [upbf_pkg::IdxW-1:0]   entry_index,
    input  logic [upbf_pkg::PosW-1:0]   char_pos,
    input  logic [7:0]                  char_byte,
    input  logic [upbf_pkg::LenW-1:0]   entry_length,
    input  logic                        entry_is_allow,
    input  logic                        byte_present,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic                        m_axis_tready,
    output logic                        out_valid,
    output logic                        out_decision,
    output logic                        out_matched,
    output logic [31:0]                 out_total
);

    localparam int WinBits = 8 * upbf_pkg::MaxLen;

    logic [7:0]                  pat_rd [upbf_pkg::MaxLen];
    logic [upbf_pkg::LenW-1:0]   len_reg   [upbf_pkg::NumEntries];
    logic                        allow_reg [upbf_pkg::NumEntries];
    logic [7:0]                  win_reg   [upbf_pkg::MaxLen];
    logic [upbf_pkg::LenW-1:0]   fill_reg;
    logic [upbf_pkg::LenW-1:0]   cmp_len_reg;
    logic                        cmp_allow_reg, cmp_valid_reg;
    logic                        allow_seen_reg, block_seen_reg, has_bytes_reg;
    logic                        enabled_reg;
    logic [upbf_pkg::CountBits-1:0] count_reg, count_next;
    logic                        out_valid_reg, out_dec_reg, out_match_reg;
    logic [31:0]                 out_total_reg;
    logic                        pb_we, push, hit, dec_block, dec_allow;
    logic [WinBits-1:0]          win_flat, win_aligned;
    logic [upbf_pkg::PosW-1:0]   shamt;
    logic [upbf_pkg::LenW-1:0]   len_clamped;

    assign pb_we = cmd.accept && op == upbf_pkg::OP_PBYTE;
    assign push  = cmd.accept && op == upbf_pkg::OP_URL && byte_present;

    // One bank per pattern byte position, addressed by entry.
    for (genvar p = 0; p < upbf_pkg::MaxLen; p++) begin : g_bank
        upbf_ram #(.WIDTH(8), .DEPTH(upbf_pkg::NumEntries)) u_bank (
            .aclk  (aclk),
            .we    (pb_we && char_pos == upbf_pkg::PosW'(p)),
            .waddr (entry_index),
            .wdata (upbf_pkg::to_lower(char_byte)),
            .re    (cmd.scan_rd),
            .raddr (cmd.scan_addr),
            .rdata (pat_rd[p])
        );
        assign win_flat[8*p +: 8] = win_reg[p];
    end

    // Align the newest len bytes of the window to byte 0.
    assign shamt       = upbf_pkg::PosW'(upbf_pkg::LenW'(upbf_pkg::MaxLen) - cmp_len_reg);
    assign win_aligned = win_flat >> {shamt, 3'b000};

    always_comb begin
        hit = cmp_valid_reg && cmp_len_reg != '0 && cmp_len_reg <= fill_reg;
        for (int i = 0; i < upbf_pkg::MaxLen; i++) begin
            if (upbf_pkg::LenW'(i) < cmp_len_reg && win_aligned[8*i +: 8] != pat_rd[i]) begin
                hit = 1'b0;
            end
        end
    end

    assign len_clamped = (entry_length > upbf_pkg::LenW'(upbf_pkg::MaxLen))
                       ? upbf_pkg::LenW'(upbf_pkg::MaxLen) : entry_length;

    // Decision at end of URL.
    assign dec_allow = enabled_reg && has_bytes_reg && allow_seen_reg;
    assign dec_block = enabled_reg && has_bytes_reg && !allow_seen_reg && block_seen_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.accept && op == upbf_pkg::OP_CLEAR) begin
            count_next = '0;
        end else if (cmd.finish && dec_block && !(&count_reg)) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < upbf_pkg::NumEntries; e++) begin
                len_reg[e]   <= '0;
                allow_reg[e] <= 1'b0;
            end
            fill_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            allow_seen_reg <= 1'b0;
            block_seen_reg <= 1'b0;
            has_bytes_reg  <= 1'b0;
            enabled_reg    <= 1'b1;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enabled_reg <= cfg_wr_data;
            end
            if (cmd.accept && op == upbf_pkg::OP_HEADER) begin
                len_reg[entry_index]   <= len_clamped;
                allow_reg[entry_index] <= entry_is_allow;
            end
            count_reg     <= count_next;
            cmp_valid_reg <= cmd.scan_rd;
            if (push) begin
                has_bytes_reg <= 1'b1;
                if (fill_reg < upbf_pkg::LenW'(upbf_pkg::MaxLen)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (hit) begin
                if (cmp_allow_reg) begin
                    allow_seen_reg <= 1'b1;
                end else begin
                    block_seen_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                fill_reg       <= '0;
                allow_seen_reg <= 1'b0;
                block_seen_reg <= 1'b0;
                has_bytes_reg  <= 1'b0;
                out_valid_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (push) begin
            for (int j = 0; j < upbf_pkg::MaxLen - 1; j++) begin
                win_reg[j] <= win_reg[j+1];
            end
            win_reg[upbf_pkg::MaxLen-1] <= upbf_pkg::to_lower(char_byte);
        end
        if (cmd.scan_rd) begin
            cmp_len_reg   <= len_reg[cmd.scan_addr];
            cmp_allow_reg <= allow_reg[cmd.scan_addr];
        end
        if (cmd.finish) begin
            out_dec_reg   <= dec_block;
            out_match_reg <= dec_allow;
            out_total_reg <= 32'(count_next);
        end
    end

    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_decision    = out_dec_reg;
    assign out_matched     = out_match_reg;
    assign out_total       = out_total_reg;

endmodule
